// ===== sv/gjd_pkg.sv =====
// ----------------------------------------------------------------------------
// gjd_pkg
// Shared types, constants and small helper functions of the Gregorian and
// Jalali date converter pipeline.
// ----------------------------------------------------------------------------
package gjd_pkg;

  localparam int JalEpochOfs  = 355666;
  localparam int GregEpochOfs = 355668;
  localparam int JalYearOfs   = 1595;
  localparam int CycJal33     = 12053;
  localparam int CycQuad      = 1461;
  localparam int CycGreg400   = 146097;
  localparam int CycGreg100   = 36524;
  localparam int DaysYear     = 365;
  localparam int JalFirstHalf = 186;
  localparam int MonthsYear   = 12;

  localparam int Recip25      = ((1 << 15) + 24) / 25;
  localparam int Recip33      = ((1 << 15) + 32) / 33;
  localparam int Div12053M    = (1 << 21) / CycJal33;
  localparam int Div146097M   = (1 << 21) / CycGreg400;
  localparam int Div1461M14   = (1 << 14) / CycQuad;
  localparam int Div1461M16   = (1 << 16) / CycQuad;

  typedef struct packed {
    logic        mode;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } gjd_in_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [20:0] n0;
    logic [20:0] n1;
  } gjd_dn_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [10:0] n0;
    logic [11:0] yr0;
    logic [15:0] n1;
    logic [1:0]  q100;
    logic [12:0] yr1;
  } gjd_era_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [3:0]  m0;
    logic [4:0]  d0;
    logic [11:0] yr0;
    logic [8:0]  n1d;
    logic        leap;
    logic [12:0] yr1;
  } gjd_quad_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        err;
  } gjd_res_t;

  function automatic logic [8:0] greg_mstart(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] jal_moff(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd62;
      4'd4:    v = 9'd93;
      4'd5:    v = 9'd124;
      4'd6:    v = 9'd155;
      4'd7:    v = 9'd186;
      4'd8:    v = 9'd216;
      4'd9:    v = 9'd246;
      4'd10:   v = 9'd276;
      4'd11:   v = 9'd306;
      4'd12:   v = 9'd336;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Days before the start of month k + 1 of a Gregorian year, k in 1..11.
  function automatic logic [8:0] greg_cum(input logic [3:0] k, input logic leap);
    logic [8:0] v;
    unique case (k)
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && k >= 4'd2) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

  // Exact quotient by 25 for values below 1124.
  function automatic logic [5:0] div25(input logic [10:0] y);
    logic [21:0] p;
    p = 22'(y) * 22'(Recip25);
    return p[20:15];
  endfunction

  // Whole years elapsed inside a four-year cycle for a day offset below 1461.
  function automatic logic [1:0] quad_year(input logic [10:0] n);
    logic [1:0] q;
    if (n >= 11'(3 * DaysYear + 1)) begin
      q = 2'd3;
    end else if (n >= 11'(2 * DaysYear + 1)) begin
      q = 2'd2;
    end else if (n >= 11'(DaysYear + 1)) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

endpackage

// ===== sv/gregorian_jalali_date_converter_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_jalali_date_converter_unit
// Converts a date between the Gregorian and Jalali calendars.
// ----------------------------------------------------------------------------
// The input channel carries one date per transaction: in_mode selects the
// direction (0 for Gregorian to Jalali, 1 for Jalali to Gregorian), and
// in_year_in, in_month_in and in_day_in hold the source date. Each accepted
// transaction yields exactly one result transaction on the output channel.
// A month outside 1..12 raises out_input_error with a zero date.
// The conversion runs through eleven register stages, the last of which is
// the output register. A new transaction can be accepted every cycle while
// in_stall is low. The pipeline advances as a whole: while out_valid is
// high and out_stall is asserted every stage holds, and in_stall is raised
// for the same cycle. Nothing is lost or repeated across a stall. Reset
// clears all stage valid bits, leaving the pipeline empty; no state is kept
// between transactions.
// ----------------------------------------------------------------------------
module gregorian_jalali_date_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [11:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic        out_input_error
);

  logic               en;
  gjd_pkg::gjd_in_t   din;
  logic               dn_vld, era_vld, quad_vld;
  gjd_pkg::gjd_dn_t   dn_d;
  gjd_pkg::gjd_era_t  era_d;
  gjd_pkg::gjd_quad_t quad_d;
  gjd_pkg::gjd_res_t  res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign din.mode  = in_mode;
  assign din.year  = in_year_in;
  assign din.month = in_month_in;
  assign din.day   = in_day_in;

  gjd_daynum u_daynum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .d_i   (din),
    .vld_o (dn_vld),
    .d_o   (dn_d)
  );

  gjd_era u_era (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (dn_vld),
    .d_i   (dn_d),
    .vld_o (era_vld),
    .d_o   (era_d)
  );

  gjd_quad u_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (era_vld),
    .d_i   (era_d),
    .vld_o (quad_vld),
    .d_o   (quad_d)
  );

  gjd_month u_month (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (quad_vld),
    .d_i   (quad_d),
    .vld_o (out_valid),
    .d_o   (res)
  );

  assign out_year_out    = res.year;
  assign out_month_out   = res.month;
  assign out_day_out     = res.day;
  assign out_input_error = res.err;

endmodule

// ===== sv/gjd_daynum.sv =====
// ----------------------------------------------------------------------------
// gjd_daynum
// Three pipeline stages that turn the source date into day counts from the
// common epoch, one for each conversion direction.
// ----------------------------------------------------------------------------
module gjd_daynum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  gjd_pkg::gjd_in_t  d_i,
  output logic              vld_o,
  output gjd_pkg::gjd_dn_t  d_o
);

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [20:0] g365;
    logic [10:0] g_x4;
    logic [5:0]  g_q100;
    logic [3:0]  g_q400;
    logic [8:0]  g_mst;
    logic [12:0] jy2;
    logic [7:0]  j_q33;
    logic [8:0]  j_moff;
    logic [4:0]  day;
  } dn_s1_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [20:0] n0;
    logic [20:0] j365;
    logic [7:0]  j_q33;
    logic [3:0]  j_r33t;
    logic [8:0]  j_moff;
    logic [4:0]  day;
  } dn_s2_t;

  logic [2:0]       vld_r;
  dn_s1_t           s1_r, s1_nxt;
  dn_s2_t           s2_r, s2_nxt;
  gjd_pkg::gjd_dn_t s3_r, s3_nxt;

  logic [12:0] gy2, gx3, gx99, gx399, jy2;
  logic [22:0] p33;
  logic [12:0] r33w;
  logic [6:0]  r33p3;

  always_comb begin
    gy2   = {1'b0, d_i.year} + 13'(d_i.month > 4'd2);
    gx3   = gy2 + 13'd3;
    gx99  = gy2 + 13'd99;
    gx399 = gy2 + 13'd399;
    jy2   = {1'b0, d_i.year} + 13'(gjd_pkg::JalYearOfs);
    p33   = 23'(jy2) * 23'(gjd_pkg::Recip33);
    s1_nxt.mode   = d_i.mode;
    s1_nxt.err    = (d_i.month == 4'd0) || (d_i.month > 4'(gjd_pkg::MonthsYear));
    s1_nxt.g365   = 21'(d_i.year) * 21'(gjd_pkg::DaysYear);
    s1_nxt.g_x4   = gx3[12:2];
    s1_nxt.g_q100 = gjd_pkg::div25(gx99[12:2]);
    s1_nxt.g_q400 = 4'(gjd_pkg::div25(2'b00 + 11'(gx399[12:4])));
    s1_nxt.g_mst  = gjd_pkg::greg_mstart(d_i.month);
    s1_nxt.jy2    = jy2;
    s1_nxt.j_q33  = p33[22:15];
    s1_nxt.j_moff = gjd_pkg::jal_moff(d_i.month);
    s1_nxt.day    = d_i.day;
  end

  always_comb begin
    r33w  = s1_r.jy2 - 13'(s1_r.j_q33) * 13'd33;
    r33p3 = 7'(r33w[5:0]) + 7'd3;
    s2_nxt.mode   = s1_r.mode;
    s2_nxt.err    = s1_r.err;
    s2_nxt.n0     = 21'(gjd_pkg::JalEpochOfs) + s1_r.g365 + 21'(s1_r.g_x4)
                  + 21'(s1_r.g_q400) + 21'(s1_r.day) + 21'(s1_r.g_mst)
                  - 21'(s1_r.g_q100);
    s2_nxt.j365   = 21'(s1_r.jy2) * 21'(gjd_pkg::DaysYear);
    s2_nxt.j_q33  = s1_r.j_q33;
    s2_nxt.j_r33t = r33p3[5:2];
    s2_nxt.j_moff = s1_r.j_moff;
    s2_nxt.day    = s1_r.day;
  end

  always_comb begin
    s3_nxt.mode = s2_r.mode;
    s3_nxt.err  = s2_r.err;
    s3_nxt.n0   = s2_r.n0;
    s3_nxt.n1   = s2_r.j365 + 21'({s2_r.j_q33, 3'b000}) + 21'(s2_r.j_r33t)
                + 21'(s2_r.day) + 21'(s2_r.j_moff) - 21'(gjd_pkg::GregEpochOfs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign vld_o = vld_r[2];
  assign d_o   = s3_r;

endmodule

// ===== sv/gjd_era.sv =====
// ----------------------------------------------------------------------------
// gjd_era
// Four pipeline stages that split the day counts into 33-year Jalali cycles
// and 400-year and 100-year Gregorian cycles, followed by the Jalali
// four-year cycle.
// ----------------------------------------------------------------------------
module gjd_era (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  gjd_pkg::gjd_dn_t  d_i,
  output logic              vld_o,
  output gjd_pkg::gjd_era_t d_o
);

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [20:0] n0;
    logic [7:0]  q0e;
    logic [20:0] n1;
    logic [3:0]  q1e;
  } era_s4_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [13:0] r0;
    logic [7:0]  q0;
    logic [17:0] r1;
    logic [3:0]  q1;
  } era_s5_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [13:0] r0;
    logic [3:0]  q4e0;
    logic [11:0] yr0;
    logic [17:0] r1;
    logic [1:0]  q100;
    logic [12:0] yr1;
  } era_s6_t;

  logic [3:0]        vld_r;
  era_s4_t           s4_r, s4_nxt;
  era_s5_t           s5_r, s5_nxt;
  era_s6_t           s6_r, s6_nxt;
  gjd_pkg::gjd_era_t s7_r, s7_nxt;

  logic [28:0] p0;
  logic [24:0] p1;
  logic [20:0] r0w, r1w;
  logic        fix0, fix1;
  logic [17:0] p4;
  logic [13:0] w0;
  logic        fix4;
  logic [3:0]  q4;
  logic        cent;
  logic [17:0] rem;

  always_comb begin
    p0 = 29'(d_i.n0) * 29'(gjd_pkg::Div12053M);
    p1 = 25'(d_i.n1) * 25'(gjd_pkg::Div146097M);
    s4_nxt.mode = d_i.mode;
    s4_nxt.err  = d_i.err;
    s4_nxt.n0   = d_i.n0;
    s4_nxt.q0e  = p0[28:21];
    s4_nxt.n1   = d_i.n1;
    s4_nxt.q1e  = p1[24:21];
  end

  always_comb begin
    r0w  = s4_r.n0 - 21'(s4_r.q0e) * 21'(gjd_pkg::CycJal33);
    fix0 = r0w >= 21'(gjd_pkg::CycJal33);
    r1w  = s4_r.n1 - 21'(s4_r.q1e) * 21'(gjd_pkg::CycGreg400);
    fix1 = r1w >= 21'(gjd_pkg::CycGreg400);
    s5_nxt.mode = s4_r.mode;
    s5_nxt.err  = s4_r.err;
    s5_nxt.r0   = fix0 ? 14'(r0w - 21'(gjd_pkg::CycJal33)) : 14'(r0w);
    s5_nxt.q0   = s4_r.q0e + 8'(fix0);
    s5_nxt.r1   = fix1 ? 18'(r1w - 21'(gjd_pkg::CycGreg400)) : 18'(r1w);
    s5_nxt.q1   = s4_r.q1e + 4'(fix1);
  end

  always_comb begin
    p4 = 18'(s5_r.r0) * 18'(gjd_pkg::Div1461M14);
    s6_nxt.mode = s5_r.mode;
    s6_nxt.err  = s5_r.err;
    s6_nxt.r0   = s5_r.r0;
    s6_nxt.q4e0 = p4[17:14];
    s6_nxt.yr0  = 12'(s5_r.q0) * 12'd33 - 12'(gjd_pkg::JalYearOfs);
    s6_nxt.r1   = s5_r.r1;
    if (s5_r.r1 >= 18'(3 * gjd_pkg::CycGreg100 + 1)) begin
      s6_nxt.q100 = 2'd3;
    end else if (s5_r.r1 >= 18'(2 * gjd_pkg::CycGreg100 + 1)) begin
      s6_nxt.q100 = 2'd2;
    end else if (s5_r.r1 >= 18'(gjd_pkg::CycGreg100 + 1)) begin
      s6_nxt.q100 = 2'd1;
    end else begin
      s6_nxt.q100 = 2'd0;
    end
    s6_nxt.yr1  = 13'(s5_r.q1) * 13'd400;
  end

  always_comb begin
    w0   = s6_r.r0 - 14'(s6_r.q4e0) * 14'(gjd_pkg::CycQuad);
    fix4 = w0 >= 14'(gjd_pkg::CycQuad);
    q4   = s6_r.q4e0 + 4'(fix4);
    cent = s6_r.q100 != 2'd0;
    rem  = s6_r.r1 - 18'(cent) - 18'(s6_r.q100) * 18'(gjd_pkg::CycGreg100);
    if (cent && rem >= 18'(gjd_pkg::DaysYear)) begin
      rem = rem + 18'd1;
    end
    s7_nxt.mode = s6_r.mode;
    s7_nxt.err  = s6_r.err;
    s7_nxt.n0   = fix4 ? 11'(w0 - 14'(gjd_pkg::CycQuad)) : 11'(w0);
    s7_nxt.yr0  = s6_r.yr0 + 12'({q4, 2'b00});
    s7_nxt.n1   = 16'(rem);
    s7_nxt.q100 = s6_r.q100;
    s7_nxt.yr1  = s6_r.yr1 + 13'(s6_r.q100) * 13'd100;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
    end
  end

  assign vld_o = vld_r[3];
  assign d_o   = s7_r;

endmodule

// ===== sv/gjd_quad.sv =====
// ----------------------------------------------------------------------------
// gjd_quad
// Three pipeline stages that resolve the year inside the four-year cycle,
// finish the Jalali month and day, and find the Gregorian leap-year flag.
// ----------------------------------------------------------------------------
module gjd_quad (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  gjd_pkg::gjd_era_t  d_i,
  output logic               vld_o,
  output gjd_pkg::gjd_quad_t d_o
);

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [8:0]  n0d;
    logic [11:0] yr0;
    logic [15:0] n1;
    logic [4:0]  q4e1;
    logic [1:0]  q100;
    logic [12:0] yr1;
  } quad_s8_t;

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [3:0]  m0;
    logic [4:0]  d0;
    logic [11:0] yr0;
    logic [10:0] n1c;
    logic [4:0]  q4;
    logic [1:0]  q100;
    logic [12:0] yr1;
  } quad_s9_t;

  logic [2:0]         vld_r;
  quad_s8_t           s8_r, s8_nxt;
  quad_s9_t           s9_r, s9_nxt;
  gjd_pkg::gjd_quad_t s10_r, s10_nxt;

  logic [1:0]  qy0, qy1;
  logic [21:0] p1;
  logic [15:0] w1;
  logic        fix1;
  logic [4:0]  q4;
  logic [8:0]  t0;
  logic [2:0]  qm;

  always_comb begin
    qy0 = gjd_pkg::quad_year(d_i.n0);
    p1  = 22'(d_i.n1) * 22'(gjd_pkg::Div1461M16);
    s8_nxt.mode = d_i.mode;
    s8_nxt.err  = d_i.err;
    s8_nxt.n0d  = 9'(d_i.n0 - 11'(qy0 != 2'd0) - 11'(qy0) * 11'(gjd_pkg::DaysYear));
    s8_nxt.yr0  = d_i.yr0 + 12'(qy0);
    s8_nxt.n1   = d_i.n1;
    s8_nxt.q4e1 = p1[20:16];
    s8_nxt.q100 = d_i.q100;
    s8_nxt.yr1  = d_i.yr1;
  end

  always_comb begin
    qm = 3'd0;
    t0 = 9'd0;
    if (s8_r.n0d < 9'(gjd_pkg::JalFirstHalf)) begin
      for (int k = 1; k <= 5; k++) begin
        if (s8_r.n0d >= 9'(31 * k)) begin
          qm = qm + 3'd1;
        end
      end
      s9_nxt.m0 = 4'd1 + 4'(qm);
      s9_nxt.d0 = 5'(s8_r.n0d - 9'(qm) * 9'd31 + 9'd1);
    end else begin
      t0 = s8_r.n0d - 9'(gjd_pkg::JalFirstHalf);
      for (int k = 1; k <= 5; k++) begin
        if (t0 >= 9'(30 * k)) begin
          qm = qm + 3'd1;
        end
      end
      s9_nxt.m0 = 4'd7 + 4'(qm);
      s9_nxt.d0 = 5'(t0 - 9'(qm) * 9'd30 + 9'd1);
    end
    w1   = s8_r.n1 - 16'(s8_r.q4e1) * 16'(gjd_pkg::CycQuad);
    fix1 = w1 >= 16'(gjd_pkg::CycQuad);
    q4   = s8_r.q4e1 + 5'(fix1);
    s9_nxt.mode = s8_r.mode;
    s9_nxt.err  = s8_r.err;
    s9_nxt.yr0  = s8_r.yr0;
    s9_nxt.n1c  = fix1 ? 11'(w1 - 16'(gjd_pkg::CycQuad)) : 11'(w1);
    s9_nxt.q4   = q4;
    s9_nxt.q100 = s8_r.q100;
    s9_nxt.yr1  = s8_r.yr1 + 13'({q4, 2'b00});
  end

  always_comb begin
    qy1 = gjd_pkg::quad_year(s9_r.n1c);
    s10_nxt.mode = s9_r.mode;
    s10_nxt.err  = s9_r.err;
    s10_nxt.m0   = s9_r.m0;
    s10_nxt.d0   = s9_r.d0;
    s10_nxt.yr0  = s9_r.yr0;
    s10_nxt.n1d  = 9'(s9_r.n1c - 11'(qy1 != 2'd0) - 11'(qy1) * 11'(gjd_pkg::DaysYear));
    s10_nxt.leap = (qy1 == 2'd0) && ((s9_r.q4 != 5'd0) || (s9_r.q100 == 2'd0));
    s10_nxt.yr1  = s9_r.yr1 + 13'(qy1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      s10_r <= s10_nxt;
    end
  end

  assign vld_o = vld_r[2];
  assign d_o   = s10_r;

endmodule

// ===== sv/gjd_month.sv =====
// ----------------------------------------------------------------------------
// gjd_month
// Last pipeline stage: finds the Gregorian month and day from the day of the
// year, selects the result of the requested direction and holds it in the
// output register.
// ----------------------------------------------------------------------------
module gjd_month (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  gjd_pkg::gjd_quad_t d_i,
  output logic               vld_o,
  output gjd_pkg::gjd_res_t  d_o
);

  logic              vld_r;
  gjd_pkg::gjd_res_t res_r, res_nxt;

  logic [8:0] day1, base, total;
  logic [3:0] cnt;
  logic [3:0] m1;
  logic [4:0] d1;

  always_comb begin
    day1  = d_i.n1d + 9'd1;
    total = 9'(gjd_pkg::DaysYear) + 9'(d_i.leap);
    cnt   = 4'd0;
    for (int k = 1; k < gjd_pkg::MonthsYear; k++) begin
      if (day1 > gjd_pkg::greg_cum(4'(k), d_i.leap)) begin
        cnt = cnt + 4'd1;
      end
    end
    base = gjd_pkg::greg_cum(cnt, d_i.leap);
    if (day1 > total) begin
      m1 = 4'(gjd_pkg::MonthsYear);
      d1 = 5'(day1 - total);
    end else begin
      m1 = cnt + 4'd1;
      d1 = 5'(day1 - base);
    end
    if (d_i.err) begin
      res_nxt.year  = 12'd0;
      res_nxt.month = 4'd0;
      res_nxt.day   = 5'd0;
    end else if (d_i.mode) begin
      res_nxt.year  = d_i.yr1[11:0];
      res_nxt.month = m1;
      res_nxt.day   = d1;
    end else begin
      res_nxt.year  = d_i.yr0;
      res_nxt.month = d_i.m0;
      res_nxt.day   = d_i.d0;
    end
    res_nxt.err = d_i.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = res_r;

endmodule
